// ===== hw/rtl/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared constants, codes, types and data conversions for the three-class
// priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

    // Geometry of each class store.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Field widths of the transaction ports.
    localparam int REQ_W   = 2;
    localparam int VAL_W   = 32;
    localparam int PRI_W   = 2;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 6;

    // Derived widths.
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = $clog2(3 * DEPTH + 1);
    localparam int ADDR_W = PRI_W + IDX_W;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Class codes; the class code also selects the region of the store.
    localparam logic [PRI_W-1:0] PRI_NONE = 2'd0;
    localparam logic [PRI_W-1:0] PRI_LOW  = 2'd1;
    localparam logic [PRI_W-1:0] PRI_MID  = 2'd2;
    localparam logic [PRI_W-1:0] PRI_HIGH = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPRI = 2'd3;

    // Outcome of one request, as worked out by the pointer unit.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               wr_en;
        logic               rd_en;
        logic [ADDR_W-1:0]  addr;
        logic [PRI_W-1:0]   pop_pri;
        logic [TOTAL_W-1:0] total;
        logic               empty;
    } t_decision;

    // Keeps the low DATA_WIDTH bits of the sign-extended input value.
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] s;
        logic signed [63:0]      w;
        s = v;
        w = 64'(s);
        return w[DATA_WIDTH-1:0];
    endfunction

    // Sign-extends a stored word and reports its low 32 bits.
    function automatic logic [VAL_W-1:0] from_store(input logic [DATA_WIDTH-1:0] d);
        logic signed [DATA_WIDTH-1:0] s;
        logic signed [63:0]           w;
        s = d;
        w = 64'(s);
        return w[VAL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/tpq_ram.sv =====
// ----------------------------------------------------------------------------
// tpq_ram
// Single-port synchronous RAM with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module tpq_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tpq_ptr.sv =====
// ----------------------------------------------------------------------------
// tpq_ptr
// Stack levels and FIFO indices of the three classes; decides each request.
// ----------------------------------------------------------------------------
module tpq_ptr (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [tpq_pkg::REQ_W-1:0]  i_req_type,
    input  logic [tpq_pkg::PRI_W-1:0]  i_priority_req,
    output tpq_pkg::t_decision         o_dec
);

    import tpq_pkg::*;

    logic [CNT_W-1:0] r_high_top, n_high_top;
    logic [CNT_W-1:0] r_mid_top,  n_mid_top;
    logic [CNT_W-1:0] r_low_fill, n_low_fill;
    logic [IDX_W-1:0] r_low_head, n_low_head;
    logic [IDX_W-1:0] r_low_tail, n_low_tail;
    logic [SUM_W-1:0] sum;
    t_decision        dec;

    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    always_comb begin
        n_high_top  = r_high_top;
        n_mid_top   = r_mid_top;
        n_low_fill  = r_low_fill;
        n_low_head  = r_low_head;
        n_low_tail  = r_low_tail;
        dec         = '0;
        dec.status  = ST_OK;
        dec.pop_pri = PRI_NONE;
        case (i_req_type)
            REQ_INSERT: begin
                case (i_priority_req)
                    PRI_HIGH: begin
                        if (r_high_top >= CNT_W'(DEPTH)) begin
                            dec.status = ST_FULL;
                        end else begin
                            dec.wr_en  = 1'b1;
                            dec.addr   = {PRI_HIGH, r_high_top[IDX_W-1:0]};
                            n_high_top = r_high_top + 1'b1;
                        end
                    end
                    PRI_MID: begin
                        if (r_mid_top >= CNT_W'(DEPTH)) begin
                            dec.status = ST_FULL;
                        end else begin
                            dec.wr_en = 1'b1;
                            dec.addr  = {PRI_MID, r_mid_top[IDX_W-1:0]};
                            n_mid_top = r_mid_top + 1'b1;
                        end
                    end
                    PRI_LOW: begin
                        if (r_low_fill >= CNT_W'(DEPTH)) begin
                            dec.status = ST_FULL;
                        end else begin
                            dec.wr_en  = 1'b1;
                            dec.addr   = {PRI_LOW, r_low_tail};
                            n_low_tail = next_index(r_low_tail);
                            n_low_fill = r_low_fill + 1'b1;
                        end
                    end
                    default: begin
                        dec.status = ST_BADPRI;
                    end
                endcase
            end
            REQ_POP: begin
                if (r_high_top != '0) begin
                    n_high_top  = r_high_top - 1'b1;
                    dec.rd_en   = 1'b1;
                    dec.addr    = {PRI_HIGH, n_high_top[IDX_W-1:0]};
                    dec.pop_pri = PRI_HIGH;
                end else if (r_mid_top != '0) begin
                    n_mid_top   = r_mid_top - 1'b1;
                    dec.rd_en   = 1'b1;
                    dec.addr    = {PRI_MID, n_mid_top[IDX_W-1:0]};
                    dec.pop_pri = PRI_MID;
                end else if (r_low_fill != '0) begin
                    dec.rd_en   = 1'b1;
                    dec.addr    = {PRI_LOW, r_low_head};
                    dec.pop_pri = PRI_LOW;
                    n_low_head  = next_index(r_low_head);
                    n_low_fill  = r_low_fill - 1'b1;
                end else begin
                    dec.status = ST_EMPTY;
                end
            end
            REQ_CLEAR: begin
                n_high_top = '0;
                n_mid_top  = '0;
                n_low_fill = '0;
                n_low_head = '0;
                n_low_tail = '0;
            end
            default: begin
            end
        endcase
        sum       = SUM_W'(n_high_top) + SUM_W'(n_mid_top) + SUM_W'(n_low_fill);
        dec.total = TOTAL_W'(sum);
        dec.empty = (sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_top <= '0;
            r_mid_top  <= '0;
            r_low_fill <= '0;
            r_low_head <= '0;
            r_low_tail <= '0;
        end else if (i_take) begin
            r_high_top <= n_high_top;
            r_mid_top  <= n_mid_top;
            r_low_fill <= n_low_fill;
            r_low_head <= n_low_head;
            r_low_tail <= n_low_tail;
        end
    end

    assign o_dec = dec;

endmodule

// ===== hw/rtl/three_level_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_queue_unit
// Priority queue with three classes held in one synchronous store: classes
// three and two behave as stacks, class one as a circular FIFO.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   req_type, value, priority_req
// out      output     o_out_valid / i_out_stall status, popped_value,
//                                               popped_priority, total_count,
//                                               is_empty
//
// An insert, a clear, an empty pop or an unused request loads the output
// register; a removing pop waits in S_POP on the store's registered read.
// Only one request is in flight at a time, so a read never meets a write to
// the same entry within the store.
// Reset clears the stack levels and FIFO indices; the store itself is not
// cleared, since no entry is read before it has been written.
// A stalled result holds the output register and, through it, the input.
//
module three_level_priority_queue_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tpq_pkg::REQ_W-1:0]    i_in_req_type,
    input  logic [tpq_pkg::VAL_W-1:0]    i_in_value,
    input  logic [tpq_pkg::PRI_W-1:0]    i_in_priority_req,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tpq_pkg::STAT_W-1:0]   o_out_status,
    output logic [tpq_pkg::VAL_W-1:0]    o_out_popped_value,
    output logic [tpq_pkg::PRI_W-1:0]    o_out_popped_priority,
    output logic [tpq_pkg::TOTAL_W-1:0]  o_out_total_count,
    output logic                         o_out_is_empty
);

    import tpq_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_POP
    } t_state;

    t_state               r_state;
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [VAL_W-1:0]     r_value;
    logic [PRI_W-1:0]     r_pri;
    logic [TOTAL_W-1:0]   r_total;
    logic                 r_empty;

    // Bookkeeping of a pop whose data is still on its way out of the store.
    logic [PRI_W-1:0]     r_pend_pri;
    logic [TOTAL_W-1:0]   r_pend_total;
    logic                 r_pend_empty;

    logic                 out_blocked;
    logic                 in_take;
    logic                 out_load;
    logic                 n_out_valid;
    t_decision            dec;
    logic [DATA_WIDTH-1:0] rdata;

    // The output register is free when it is empty or being emptied now.
    assign out_blocked = r_out_valid && i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || out_blocked;
    assign in_take     = i_in_valid && !o_in_stall;

    // The output register is loaded by a request that needs no store read,
    // or by a pop once its data has come out of the store. A transaction on
    // the output frees it otherwise.
    assign out_load    = ((r_state == S_IDLE) && in_take && !dec.rd_en)
                      || ((r_state == S_POP) && !out_blocked);
    assign n_out_valid = out_load || (r_out_valid && i_out_stall);

    tpq_ptr u_ptr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (in_take),
        .i_req_type     (i_in_req_type),
        .i_priority_req (i_in_priority_req),
        .o_dec          (dec)
    );

    // The class code forms the upper address bits, so each class owns its
    // own region of the one store.
    tpq_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_wr_en (in_take && dec.wr_en),
        .i_rd_en (in_take && dec.rd_en),
        .i_addr  (dec.addr),
        .i_wdata (to_store(i_in_value)),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (dec.rd_en) begin
                            // Data arrives from the store in the next cycle.
                            r_state      <= S_POP;
                            r_pend_pri   <= dec.pop_pri;
                            r_pend_total <= dec.total;
                            r_pend_empty <= dec.empty;
                        end else begin
                            r_status    <= dec.status;
                            r_value     <= '0;
                            r_pri       <= PRI_NONE;
                            r_total     <= dec.total;
                            r_empty     <= dec.empty;
                        end
                    end
                end
                S_POP: begin
                    // The store's read register holds its data while we wait.
                    if (!out_blocked) begin
                        r_state     <= S_IDLE;
                        r_status    <= ST_OK;
                        r_value     <= from_store(rdata);
                        r_pri       <= r_pend_pri;
                        r_total     <= r_pend_total;
                        r_empty     <= r_pend_empty;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_status          = r_status;
    assign o_out_popped_value    = r_value;
    assign o_out_popped_priority = r_pri;
    assign o_out_total_count     = r_total;
    assign o_out_is_empty        = r_empty;

`ifndef SYNTH
    // A pop that finds an entry must wait for the store's read data.
    a_pop_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && dec.rd_en) |=> (r_state == S_POP))
        else $error("pop with data did not enter the read-wait state");

    // No new request may enter while a pop is still reading the store.
    a_no_take_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !in_take)
        else $error("request accepted during a pending pop");

    // The store is never written and read for the same request.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dec.wr_en && dec.rd_en))
        else $error("store written and read for one request");

    // A reported class implies a successful pop.
    a_pri_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_pri != PRI_NONE)) |-> (r_status == ST_OK))
        else $error("popped class reported with an error status");
`endif

endmodule
